// ----- hw/rtl/modular_inverse_extended_euclid_core_macros.svh -----
// ----------------------------------------------------------------------------
// modular inverse core assertion macros
// shared concurrent assertion forms, clocked on clk_i, quiet while in reset
// ----------------------------------------------------------------------------
`ifndef MODULAR_INVERSE_EXTENDED_EUCLID_CORE_MACROS_SVH
`define MODULAR_INVERSE_EXTENDED_EUCLID_CORE_MACROS_SVH

// property that must hold at every clock edge out of reset
`define MIEEC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define MIEEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/modinv_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modinv_pkg
// shared types and defaults of the modular inverse core
// ----------------------------------------------------------------------------
package modinv_pkg;

  localparam int WidthDefault = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ALIGN,
    ST_DIVIDE,
    ST_UPDATE,
    ST_ABS,
    ST_REDUCE,
    ST_FINISH
  } state_e;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic rc_zero;
    logic can_shift;
    logic k_zero;
  } sts_t;

  // datapath commands from the sequencer
  typedef struct packed {
    logic busy;
    logic load;
    logic init;
    logic shift;
    logic divide;
    logic update;
    logic absval;
    logic reduce;
    logic finish;
  } ctl_t;

endpackage

// ----- hw/rtl/modinv_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modinv_step
// shared radix-2 unit: divisor alignment test, one restoring division bit
// and horner accumulation of quotient times both coefficients
// ----------------------------------------------------------------------------
module modinv_step #(
  parameter int WIDTH = modinv_pkg::WidthDefault
) (
  input  logic [WIDTH-1:0] rem_i,
  input  logic [WIDTH-1:0] dv_i,
  input  logic [WIDTH:0]   sacc_i,
  input  logic [WIDTH:0]   tacc_i,
  input  logic [WIDTH:0]   sc_i,
  input  logic [WIDTH:0]   tc_i,
  output logic             can_shift_o,
  output logic [WIDTH-1:0] rem_o,
  output logic [WIDTH:0]   sacc_o,
  output logic [WIDTH:0]   tacc_o
);

  logic qbit;

  // doubled divisor still fits under the partial remainder
  assign can_shift_o = ({dv_i, 1'b0} <= {1'b0, rem_i});

  assign qbit  = (dv_i <= rem_i);
  assign rem_o = qbit ? (rem_i - dv_i) : rem_i;

  // acc = 2*acc + qbit*coef, wraps at WIDTH+1 bits
  assign sacc_o = {sacc_i[WIDTH-1:0], 1'b0} + (qbit ? sc_i : '0);
  assign tacc_o = {tacc_i[WIDTH-1:0], 1'b0} + (qbit ? tc_i : '0);

endmodule

// ----- hw/rtl/modinv_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modinv_ctrl
// sequencer of the modular inverse core
// ----------------------------------------------------------------------------
module modinv_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  modinv_pkg::sts_t   sts_i,
  output modinv_pkg::ctl_t   ctl_o
);

  modinv_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= modinv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctl_o   = '0;
    ctl_o.busy = (state_q != modinv_pkg::ST_IDLE);
    unique case (state_q)
      modinv_pkg::ST_IDLE: begin
        if (start_i) begin
          ctl_o.load = 1'b1;
          state_d    = modinv_pkg::ST_CHECK;
        end
      end
      modinv_pkg::ST_CHECK: begin
        if (sts_i.rc_zero) begin
          state_d = modinv_pkg::ST_ABS;
        end else begin
          ctl_o.init = 1'b1;
          state_d    = modinv_pkg::ST_ALIGN;
        end
      end
      modinv_pkg::ST_ALIGN: begin
        if (sts_i.can_shift) begin
          ctl_o.shift = 1'b1;
        end else begin
          state_d = modinv_pkg::ST_DIVIDE;
        end
      end
      modinv_pkg::ST_DIVIDE: begin
        ctl_o.divide = 1'b1;
        if (sts_i.k_zero) begin
          state_d = modinv_pkg::ST_UPDATE;
        end
      end
      modinv_pkg::ST_UPDATE: begin
        ctl_o.update = 1'b1;
        state_d      = modinv_pkg::ST_CHECK;
      end
      modinv_pkg::ST_ABS: begin
        ctl_o.absval = 1'b1;
        state_d      = modinv_pkg::ST_REDUCE;
      end
      modinv_pkg::ST_REDUCE: begin
        ctl_o.reduce = 1'b1;
        state_d      = modinv_pkg::ST_FINISH;
      end
      modinv_pkg::ST_FINISH: begin
        ctl_o.finish = 1'b1;
        state_d      = modinv_pkg::ST_IDLE;
      end
      default: begin
        state_d = modinv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- hw/rtl/modular_inverse_extended_euclid_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_inverse_extended_euclid_core
// gcd, bezout coefficients and modular inverse by the extended euclid method
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand over one item (value_i, modulus_i).
// The core then stays busy while it runs the extended euclid recurrence on a
// single shared radix-2 unit, and presents the result for exactly one cycle
// with done_o high; the outputs are not held back for the receiver, so it
// must capture them in that cycle (they keep their value until the next
// result, but only the strobed cycle counts). In each quotient step the
// divisor is doubled until it would pass the remainder, then one quotient
// bit per cycle is taken while q times both coefficients is accumulated,
// then the pairs shift. Around the steps come the load, a final check of
// the remainder, and the absolute value, reduce and finish states that
// fold the coefficient into the inverse. The next item may be started in
// the same cycle that done_o shows the previous result.
// coef_value_o and coef_modulus_o are two's complement, WIDTH+1 bits.
// ----------------------------------------------------------------------------
`include "modular_inverse_extended_euclid_core_macros.svh"

module modular_inverse_extended_euclid_core #(
  parameter int WIDTH = modinv_pkg::WidthDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [WIDTH-1:0]   value_i,
  input  logic [WIDTH-1:0]   modulus_i,
  output logic               done_o,
  output logic [WIDTH:0]     coef_value_o,
  output logic [WIDTH:0]     coef_modulus_o,
  output logic [WIDTH-1:0]   gcd_value_o,
  output logic [WIDTH-1:0]   inverse_o,
  output logic               has_inverse_o
);

  localparam int KW = $clog2(WIDTH);

  localparam logic [WIDTH:0]   CoefOne = {{WIDTH{1'b0}}, 1'b1};
  localparam logic [WIDTH-1:0] WordOne = {{(WIDTH-1){1'b0}}, 1'b1};
  localparam logic [KW-1:0]    KOne    = {{(KW-1){1'b0}}, 1'b1};

  modinv_pkg::ctl_t ctl;
  modinv_pkg::sts_t sts;

  // remainder pair and the modulus kept for the final reduction
  logic [WIDTH-1:0] rp_q, rp_d, rc_q, rc_d, m_q, m_d;
  // coefficient pairs for value (s) and modulus (t)
  logic [WIDTH:0]   sp_q, sp_d, sc_q, sc_d, tp_q, tp_d, tc_q, tc_d;
  // division working set: partial remainder, shifted divisor, shift count
  logic [WIDTH-1:0] rem_q, rem_d, dv_q, dv_d;
  logic [KW-1:0]    k_q, k_d;
  // quotient times current coefficient, built one bit at a time
  logic [WIDTH:0]   sacc_q, sacc_d, tacc_q, tacc_d;
  logic             neg_q, neg_d;

  // result registers
  logic             done_q, done_d;
  logic             has_q, has_d;
  logic [WIDTH:0]   cv_q, cv_d, cm_q, cm_d;
  logic [WIDTH-1:0] gcd_q, gcd_d, inv_q, inv_d;

  logic             step_can_shift;
  logic [WIDTH-1:0] step_rem;
  logic [WIDTH:0]   step_sacc, step_tacc;
  logic [WIDTH:0]   sp_neg;

  modinv_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .ctl_o   (ctl)
  );

  modinv_step #(
    .WIDTH (WIDTH)
  ) u_step (
    .rem_i       (rem_q),
    .dv_i        (dv_q),
    .sacc_i      (sacc_q),
    .tacc_i      (tacc_q),
    .sc_i        (sc_q),
    .tc_i        (tc_q),
    .can_shift_o (step_can_shift),
    .rem_o       (step_rem),
    .sacc_o      (step_sacc),
    .tacc_o      (step_tacc)
  );

  assign sts.rc_zero   = (rc_q == '0);
  assign sts.can_shift = step_can_shift;
  assign sts.k_zero    = (k_q == '0);

  assign sp_neg = (~sp_q) + CoefOne;

  always_comb begin
    rp_d   = rp_q;
    rc_d   = rc_q;
    m_d    = m_q;
    sp_d   = sp_q;
    sc_d   = sc_q;
    tp_d   = tp_q;
    tc_d   = tc_q;
    rem_d  = rem_q;
    dv_d   = dv_q;
    k_d    = k_q;
    sacc_d = sacc_q;
    tacc_d = tacc_q;
    neg_d  = neg_q;
    cv_d   = cv_q;
    cm_d   = cm_q;
    gcd_d  = gcd_q;
    inv_d  = inv_q;
    has_d  = has_q;
    done_d = ctl.finish;

    if (ctl.load) begin
      // remainders start at (value, modulus), coefficients at identity
      rp_d = value_i;
      rc_d = modulus_i;
      m_d  = modulus_i;
      sp_d = CoefOne;
      sc_d = '0;
      tp_d = '0;
      tc_d = CoefOne;
    end
    if (ctl.init) begin
      rem_d  = rp_q;
      dv_d   = rc_q;
      k_d    = '0;
      sacc_d = '0;
      tacc_d = '0;
    end
    if (ctl.shift) begin
      dv_d = {dv_q[WIDTH-2:0], 1'b0};
      k_d  = k_q + KOne;
    end
    if (ctl.divide) begin
      rem_d  = step_rem;
      sacc_d = step_sacc;
      tacc_d = step_tacc;
      dv_d   = {1'b0, dv_q[WIDTH-1:1]};
      k_d    = k_q - KOne;
    end
    if (ctl.update) begin
      // rem_q now holds r_prev mod r_cur
      rp_d = rc_q;
      rc_d = rem_q;
      sp_d = sc_q;
      sc_d = sp_q - sacc_q;
      tp_d = tc_q;
      tc_d = tp_q - tacc_q;
    end
    if (ctl.absval) begin
      // magnitude of the value coefficient never exceeds a nonzero modulus
      neg_d = sp_q[WIDTH];
      rem_d = sp_q[WIDTH] ? sp_neg[WIDTH-1:0] : sp_q[WIDTH-1:0];
    end
    if (ctl.reduce) begin
      rem_d = (rem_q >= m_q) ? (rem_q - m_q) : rem_q;
    end
    if (ctl.finish) begin
      cv_d  = sp_q;
      cm_d  = tp_q;
      gcd_d = rp_q;
      // floor modulo: a negative coefficient folds to modulus minus remainder
      if (m_q == '0) begin
        inv_d = '0;
      end else if (neg_q && (rem_q != '0)) begin
        inv_d = m_q - rem_q;
      end else begin
        inv_d = rem_q;
      end
      has_d = (m_q != '0) && (rp_q == WordOne);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      has_q  <= 1'b0;
    end else begin
      done_q <= done_d;
      has_q  <= has_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rp_q   <= rp_d;
    rc_q   <= rc_d;
    m_q    <= m_d;
    sp_q   <= sp_d;
    sc_q   <= sc_d;
    tp_q   <= tp_d;
    tc_q   <= tc_d;
    rem_q  <= rem_d;
    dv_q   <= dv_d;
    k_q    <= k_d;
    sacc_q <= sacc_d;
    tacc_q <= tacc_d;
    neg_q  <= neg_d;
    cv_q   <= cv_d;
    cm_q   <= cm_d;
    gcd_q  <= gcd_d;
    inv_q  <= inv_d;
  end

  assign busy           = ctl.busy;
  assign done_o         = done_q;
  assign coef_value_o   = cv_q;
  assign coef_modulus_o = cm_q;
  assign gcd_value_o    = gcd_q;
  assign inverse_o      = inv_q;
  assign has_inverse_o  = has_q;

  // result strobe follows the last sequencer step and frees the core
  `MIEEC_ASSERT_NEXT(a_finish_strobe, ctl.finish, done_o && !busy, "no strobe after finish")
  // a division bit never runs against a zero divisor
  `MIEEC_ASSERT(a_divisor_nonzero, ctl.divide |-> dv_q != '0, "zero divisor")
  // reduced inverse lies below the modulus
  `MIEEC_ASSERT(a_inverse_range, done_o && m_q != '0 |-> inverse_o < m_q, "inverse not reduced")
  // gcd of a nonzero modulus is nonzero
  `MIEEC_ASSERT(a_gcd_nonzero, done_o && m_q != '0 |-> gcd_value_o != '0, "zero gcd")
  // an inverse is flagged only for coprime operands
  `MIEEC_ASSERT(a_has_inv_gcd, done_o && has_inverse_o |-> gcd_value_o == WordOne, "gcd above one")

endmodule

// ----- test/tb_modular_inverse_extended_euclid_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_modular_inverse_extended_euclid_core
// self-checking bench for the extended euclid gcd / bezout / inverse core
// ----------------------------------------------------------------------------
// A directed table covers zero operands, all-ones operands, a modulus of one,
// missing inverses and the longest fibonacci chains. Random items follow,
// weighted toward odd cases. Items without typed-in expectations are
// predicted by a behavioral euclid loop, and every strobed result is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_modular_inverse_extended_euclid_core;

  localparam int W = modinv_pkg::WidthDefault;
  localparam int NUM_RANDOM = 700;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 400;
  localparam logic [W-1:0] ALL_ONES = '1;
  localparam logic [W-1:0] TOP_BIT = ALL_ONES ^ (ALL_ONES >> 1);

  typedef struct packed {
    logic [W:0]   coef_value;
    logic [W:0]   coef_modulus;
    logic [W-1:0] gcd_value;
    logic [W-1:0] inverse;
    logic         has_inverse;
  } bezout_t;

  // typed_in set: the expected fields are given in the row itself
  typedef struct packed {
    logic [W-1:0] value;
    logic [W-1:0] modulus;
    logic         typed_in;
    bezout_t      known;
  } operand_row_t;

  localparam int NUM_DIRECTED = 19;
  operand_row_t directed_rows [NUM_DIRECTED] = '{
    '{'0,           '0,           1'b1, '{1, 0, '0, '0, 1'b0}},
    '{ALL_ONES,     '0,           1'b1, '{1, 0, ALL_ONES, '0, 1'b0}},
    '{1,            '0,           1'b1, '{1, 0, 1, '0, 1'b0}},
    '{'0,           1,            1'b1, '{0, 1, 1, '0, 1'b1}},
    '{'0,           ALL_ONES,     1'b1, '{0, 1, ALL_ONES, '0, 1'b0}},
    '{5,            1,            1'b1, '{0, 1, 1, '0, 1'b1}},
    '{ALL_ONES,     1,            1'b1, '{0, 1, 1, '0, 1'b1}},
    '{1,            7,            1'b1, '{1, 0, 1, 1, 1'b1}},
    '{ALL_ONES,     ALL_ONES,     1'b1, '{0, 1, ALL_ONES, '0, 1'b0}},
    '{3,            7,            1'b0, '0},
    '{10,           4,            1'b0, '0},
    '{6,            9,            1'b0, '0},
    '{ALL_ONES,     ALL_ONES - 1, 1'b0, '0},
    '{ALL_ONES - 1, ALL_ONES,     1'b0, '0},
    '{TOP_BIT,      ALL_ONES,     1'b0, '0},
    '{32'd1836311903, 32'd2971215073, 1'b0, '0},
    '{32'd2971215073, 32'd1836311903, 1'b0, '0},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0}
  };

  logic         clk_i;
  logic         rst_ni = 1'b0;
  logic         start = 1'b0;
  logic         busy;
  logic [W-1:0] value_i = '0;
  logic [W-1:0] modulus_i = '0;
  logic         done_o;
  logic [W:0]   coef_value_o;
  logic [W:0]   coef_modulus_o;
  logic [W-1:0] gcd_value_o;
  logic [W-1:0] inverse_o;
  logic         has_inverse_o;

  bezout_t bezout_q [$];
  int      error_count = 0;
  int      stall_cycles = 0;

  modular_inverse_extended_euclid_core #(
    .WIDTH (W)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .value_i        (value_i),
    .modulus_i      (modulus_i),
    .done_o         (done_o),
    .coef_value_o   (coef_value_o),
    .coef_modulus_o (coef_modulus_o),
    .gcd_value_o    (gcd_value_o),
    .inverse_o      (inverse_o),
    .has_inverse_o  (has_inverse_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // plain euclid recurrence on 64-bit patterns, wrapping like the hardware
  function automatic bezout_t predict_bezout(logic [W-1:0] a, logic [W-1:0] m);
    bit [63:0] r0, r1, s0, s1, t0, t1, q, nxt, mag, rr;
    bezout_t   res;
    r0 = a;
    r1 = m;
    s0 = 1;
    s1 = 0;
    t0 = 0;
    t1 = 1;
    while (r1 != 0) begin
      q   = r0 / r1;
      nxt = r0 - q * r1;
      r0  = r1;
      r1  = nxt;
      nxt = s0 - q * s1;
      s0  = s1;
      s1  = nxt;
      nxt = t0 - q * t1;
      t0  = t1;
      t1  = nxt;
    end
    res.inverse     = '0;
    res.has_inverse = 1'b0;
    // zero modulus skips the loop, so the start coefficients stay
    if (m != 0) begin
      if (s0[63]) begin
        mag = -s0;
        rr  = mag % m;
        res.inverse = (rr == 0) ? '0 : W'(m - rr);
      end else begin
        res.inverse = W'(s0 % m);
      end
      res.has_inverse = (r0 == 1);
    end
    res.coef_value   = s0[W:0];
    res.coef_modulus = t0[W:0];
    res.gcd_value    = r0[W-1:0];
    return res;
  endfunction

  function automatic logic [W-1:0] rand_operand(int bits);
    bit [63:0]    raw;
    logic [W-1:0] mask;
    raw  = {$urandom, $urandom};
    mask = (bits >= W) ? ALL_ONES : W'((64'd1 << bits) - 1);
    return raw[W-1:0] & mask;
  endfunction

  // consecutive fibonacci numbers give the longest quotient chains
  task automatic fib_pair(input int n, output logic [W-1:0] lo, output logic [W-1:0] hi);
    bit [63:0] f0, f1, nxt;
    f0 = 1;
    f1 = 1;
    repeat (n) begin
      nxt = f0 + f1;
      f0  = f1;
      f1  = nxt;
    end
    lo = f0[W-1:0];
    hi = f1[W-1:0];
  endtask

  task automatic send_item(logic [W-1:0] v, logic [W-1:0] m, bezout_t want);
    value_i   <= v;
    modulus_i <= m;
    start     <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    bezout_q.push_back(want);
  endtask

  // occasional random gap after an item unless quiet, short or spanning a whole run
  task automatic maybe_idle(bit quiet);
    if (!quiet && $urandom_range(0, 99) < 12) begin
      start <= 1'b0;
      repeat ($urandom_range(0, 1) ? $urandom_range(1, 4) : $urandom_range(1, 300))
        @(posedge clk_i);
    end
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (bezout_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic check_field(string name, logic [W:0] want, logic [W:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    bezout_t want;
    if (rst_ni && done_o) begin
      if (bezout_q.size() == 0) begin
        $display("%0t: result with no item pending, actual gcd %h", $time, gcd_value_o);
        error_count++;
      end else begin
        want = bezout_q.pop_front();
        check_field("coef_value", want.coef_value, coef_value_o);
        check_field("coef_modulus", want.coef_modulus, coef_modulus_o);
        check_field("gcd_value", (W+1)'(want.gcd_value), (W+1)'(gcd_value_o));
        check_field("inverse", (W+1)'(want.inverse), (W+1)'(inverse_o));
        check_field("has_inverse", (W+1)'(want.has_inverse), (W+1)'(has_inverse_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, stall_cycles);
      $display("tb: failure");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [W-1:0] v, m, lo, hi, g;
    int           pick;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].value, directed_rows[i].modulus,
                directed_rows[i].typed_in ? directed_rows[i].known :
                predict_bezout(directed_rows[i].value, directed_rows[i].modulus));
      maybe_idle(1'b0);
    end
    wait_results_drained();

    for (int n = 0; n < NUM_RANDOM; n++) begin
      pick = $urandom_range(0, 99);
      v = rand_operand(W);
      m = rand_operand(W);
      if (pick < 40) begin
        // full-width operands, left as drawn
      end else if (pick < 62) begin
        v = rand_operand($urandom_range(1, W));
        m = rand_operand($urandom_range(1, W));
      end else if (pick < 72) begin
        // typical key setup: value already below the modulus
        m = rand_operand($urandom_range(2, W)) | 1;
        v = v % m;
      end else if (pick < 77) begin
        m = '0;
      end else if (pick < 82) begin
        v = '0;
      end else if (pick < 87) begin
        if ($urandom_range(0, 1)) m = 1;
        else v = 1;
      end else if (pick < 94) begin
        // shared factor, so no inverse
        g = rand_operand($urandom_range(1, 12)) | 2;
        v = g * rand_operand($urandom_range(1, 16));
        m = g * rand_operand($urandom_range(1, 16));
        if ($urandom_range(0, 3) == 0) v = m;
      end else begin
        fib_pair($urandom_range(0, 45), lo, hi);
        v = $urandom_range(0, 1) ? lo : hi;
        m = (v == lo) ? hi : lo;
      end
      if (n == 120) wait_results_drained();
      send_item(v, m, predict_bezout(v, m));
      maybe_idle(n >= 250 && n < 450);
    end
    start <= 1'b0;

    @(posedge clk_i);
    while (bezout_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
